// File: rtl/lcac_pkg.sv
`default_nettype none

package lcac_pkg;

    localparam int NODE_W      = 10;
    localparam int CNT_W       = 11;
    localparam int GUARD_W     = 12;
    localparam int FIELD_NODES = 1024;

    localparam logic [CNT_W-1:0] NO_PARENT = 11'h7FF;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_PREP  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_NOANC = 2'd2;

    typedef struct packed {
        logic [1:0]        action;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic              has_parent;
    } t_in_item;

    typedef struct packed {
        logic [NODE_W-1:0] ancestor;
        logic [1:0]        status;
    } t_out_item;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } t_eng_ctl;

endpackage

`default_nettype wire

// File: rtl/lowest_common_ancestor_climb_core.sv
`default_nettype none

// Lowest common ancestor by parent climbing.
// Request channel: i_valid / o_ready with i_item (action, node_a, node_b, has_parent).
//   Load writes one parent entry. Prepare fills the depth table by climbing
//   the parents of every node below the limit; it gives no result. A query
//   gives one result on o_valid / i_ready with o_result (ancestor, status).
// A query checks the range, reads both depths, lifts the deeper node, then
//   climbs both nodes together and hands the result to the output register.
//   Each step reads the parent table (registered read) once per node moved,
//   through the single climb sequencer.
// The block takes one request at a time; o_ready is high only while idle.
// A finished result sits in the output register, so a new request is taken
// while the receiver stalls; a following query holds its result until the
// output register frees up.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_data writes node_count;
//   write it only while idle. Node_count 0 acts as 1.
// Reset (synchronous, active low) sets node_count to 1024 and idles the
// sequencer. Table contents are not cleared; load parents and prepare before
// querying.

module lowest_common_ancestor_climb_core #(
    parameter int MAX_NODES = 1024
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  lcac_pkg::t_in_item           i_item,
    output logic                         o_valid,
    input  wire                          i_ready,
    output lcac_pkg::t_out_item          o_result,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire [lcac_pkg::CNT_W-1:0]    i_cfg_data
);
    import lcac_pkg::*;

    localparam int DEPTH = (MAX_NODES < FIELD_NODES) ? MAX_NODES : FIELD_NODES;

    logic [CNT_W-1:0] r_node_count;
    logic [CNT_W-1:0] lim;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out;
    t_eng_ctl         ctl;
    t_out_item        eng_res;
    logic             start;
    logic             res_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= CNT_W'(FIELD_NODES);
        end else if (i_cfg_valid) begin
            r_node_count <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_node_count == '0) begin
            lim = CNT_W'(1);
        end else if (r_node_count > CNT_W'(DEPTH)) begin
            lim = CNT_W'(DEPTH);
        end else begin
            lim = r_node_count;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_ready     = ctl.idle;
    assign start       = i_valid && ctl.idle;
    assign res_take    = ctl.res_valid && (!r_out_valid || i_ready);

    lcac_engine #(
        .DEPTH (DEPTH)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_item     (i_item),
        .i_lim      (lim),
        .i_res_take (res_take),
        .o_ctl      (ctl),
        .o_result   (eng_res)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (res_take) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= eng_res;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // hold a finished result in the engine while the output register is stalled
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.res_valid && r_out_valid && !i_ready |=> ctl.res_valid && $stable(eng_res))
        else $error("engine dropped a result while output stalled");

    // only a query request can produce a result
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && (i_item.action != ACT_QUERY) |=> !ctl.res_valid)
        else $error("result raised by a non-query request");

    // failing status always carries a zero ancestor
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result.status != ST_OK) |-> o_result.ancestor == '0)
        else $error("nonzero ancestor on failing status");

    // never accept a request while a result is pending in the engine
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.res_valid |-> !o_ready)
        else $error("ready while result pending");

endmodule

`default_nettype wire

// File: rtl/lcac_engine.sv
`default_nettype none

module lcac_engine #(
    parameter int DEPTH = 1024
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_start,
    input  lcac_pkg::t_in_item          i_item,
    input  wire [lcac_pkg::CNT_W-1:0]   i_lim,
    input  wire                         i_res_take,
    output lcac_pkg::t_eng_ctl          o_ctl,
    output lcac_pkg::t_out_item         o_result
);
    import lcac_pkg::*;

    localparam int AW = $clog2(DEPTH);

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_PREP_RD  = 13'b0000000000010,
        S_PREP_CHK = 13'b0000000000100,
        S_Q_RDA    = 13'b0000000001000,
        S_Q_RDB    = 13'b0000000010000,
        S_Q_CHK    = 13'b0000000100000,
        S_LIFT     = 13'b0000001000000,
        S_LIFT_PAR = 13'b0000010000000,
        S_LIFT_DEP = 13'b0000100000000,
        S_MEET     = 13'b0001000000000,
        S_MEET_PP  = 13'b0010000000000,
        S_MEET_PQ  = 13'b0100000000000,
        S_DONE     = 13'b1000000000000
    } t_state;

    // parent entries, and depth entries as {cycle flag, depth}
    logic [CNT_W-1:0] mem_par [DEPTH];
    logic [CNT_W-1:0] mem_dep [DEPTH];

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_v, n_v;
    logic [NODE_W-1:0]   r_cur, n_cur;
    logic [CNT_W-1:0]    r_steps, n_steps;
    logic [NODE_W-1:0]   r_p, n_p;
    logic [NODE_W-1:0]   r_q, n_q;
    logic [NODE_W-1:0]   r_dp, n_dp;
    logic [NODE_W-1:0]   r_dq, n_dq;
    logic                r_cyc, n_cyc;
    logic [GUARD_W-1:0]  r_guard, n_guard;
    t_out_item           r_res, n_res;

    logic [CNT_W-1:0]    r_par_rd, r_dep_rd;
    logic [AW-1:0]       par_ra, dep_ra, par_wa, dep_wa;
    logic                par_we, dep_we;
    logic [CNT_W-1:0]    par_wd, dep_wd;

    logic [CNT_W-1:0]    steps_inc;
    logic [CNT_W-1:0]    v_inc;
    logic [GUARD_W-1:0]  guard_inc;
    logic                par_bad;
    logic                p_deeper;

    assign steps_inc = r_steps + 1'b1;
    assign v_inc     = r_v + 1'b1;
    assign guard_inc = r_guard + 1'b1;
    assign par_bad   = (r_par_rd >= i_lim);
    assign p_deeper  = (r_dp > r_dq);

    always_ff @(posedge i_clk) begin
        if (par_we) begin
            mem_par[par_wa] <= par_wd;
        end
        r_par_rd <= mem_par[par_ra];
    end

    always_ff @(posedge i_clk) begin
        if (dep_we) begin
            mem_dep[dep_wa] <= dep_wd;
        end
        r_dep_rd <= mem_dep[dep_ra];
    end

    always_comb begin
        n_state = r_state;
        n_v     = r_v;
        n_cur   = r_cur;
        n_steps = r_steps;
        n_p     = r_p;
        n_q     = r_q;
        n_dp    = r_dp;
        n_dq    = r_dq;
        n_cyc   = r_cyc;
        n_guard = r_guard;
        n_res   = r_res;
        par_ra  = r_cur[AW-1:0];
        dep_ra  = r_p[AW-1:0];
        par_we  = 1'b0;
        par_wa  = i_item.node_a[AW-1:0];
        par_wd  = i_item.has_parent ? {1'b0, i_item.node_b} : NO_PARENT;
        dep_we  = 1'b0;
        dep_wa  = r_v[AW-1:0];
        dep_wd  = {1'b0, r_steps[NODE_W-1:0]};

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_item.action)
                        ACT_LOAD: begin
                            par_we = ({1'b0, i_item.node_a} < i_lim);
                        end
                        ACT_PREP: begin
                            n_v     = '0;
                            n_cur   = '0;
                            n_steps = '0;
                            n_state = S_PREP_RD;
                        end
                        ACT_QUERY: begin
                            if (({1'b0, i_item.node_a} >= i_lim) ||
                                ({1'b0, i_item.node_b} >= i_lim)) begin
                                n_res   = '{ancestor: '0, status: ST_RANGE};
                                n_state = S_DONE;
                            end else begin
                                n_p     = i_item.node_a;
                                n_q     = i_item.node_b;
                                n_state = S_Q_RDA;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_PREP_RD: begin
                par_ra  = r_cur[AW-1:0];
                n_state = S_PREP_CHK;
            end
            S_PREP_CHK: begin
                if (par_bad || (steps_inc == i_lim)) begin
                    // root reached: store depth; step bound hit: flag cycle
                    dep_we = 1'b1;
                    dep_wd = par_bad ? {1'b0, r_steps[NODE_W-1:0]} : {1'b1, {NODE_W{1'b0}}};
                    if (v_inc == i_lim) begin
                        n_state = S_IDLE;
                    end else begin
                        n_v     = v_inc;
                        n_cur   = v_inc[NODE_W-1:0];
                        n_steps = '0;
                        n_state = S_PREP_RD;
                    end
                end else begin
                    n_cur   = r_par_rd[NODE_W-1:0];
                    n_steps = steps_inc;
                    n_state = S_PREP_RD;
                end
            end
            S_Q_RDA: begin
                dep_ra  = r_p[AW-1:0];
                n_state = S_Q_RDB;
            end
            S_Q_RDB: begin
                dep_ra  = r_q[AW-1:0];
                n_dp    = r_dep_rd[NODE_W-1:0];
                n_cyc   = r_dep_rd[NODE_W];
                n_state = S_Q_CHK;
            end
            S_Q_CHK: begin
                if (r_cyc || r_dep_rd[NODE_W]) begin
                    n_res   = '{ancestor: '0, status: ST_NOANC};
                    n_state = S_DONE;
                end else begin
                    n_dq    = r_dep_rd[NODE_W-1:0];
                    n_guard = '0;
                    n_state = S_LIFT;
                end
            end
            S_LIFT: begin
                par_ra = p_deeper ? r_p[AW-1:0] : r_q[AW-1:0];
                if (r_dp == r_dq) begin
                    n_guard = '0;
                    n_state = S_MEET;
                end else if (guard_inc > {i_lim, 1'b0}) begin
                    n_res   = '{ancestor: '0, status: ST_NOANC};
                    n_state = S_DONE;
                end else begin
                    n_guard = guard_inc;
                    n_state = S_LIFT_PAR;
                end
            end
            S_LIFT_PAR: begin
                dep_ra = r_par_rd[AW-1:0];
                if (par_bad) begin
                    n_res   = '{ancestor: '0, status: ST_NOANC};
                    n_state = S_DONE;
                end else begin
                    if (p_deeper) begin
                        n_p = r_par_rd[NODE_W-1:0];
                    end else begin
                        n_q = r_par_rd[NODE_W-1:0];
                    end
                    n_state = S_LIFT_DEP;
                end
            end
            S_LIFT_DEP: begin
                // side choice still holds: depths are untouched until here
                if (p_deeper) begin
                    n_dp = r_dep_rd[NODE_W-1:0];
                end else begin
                    n_dq = r_dep_rd[NODE_W-1:0];
                end
                n_state = S_LIFT;
            end
            S_MEET: begin
                par_ra = r_p[AW-1:0];
                if (r_p == r_q) begin
                    n_res   = '{ancestor: r_p, status: ST_OK};
                    n_state = S_DONE;
                end else if (guard_inc > {1'b0, i_lim}) begin
                    n_res   = '{ancestor: '0, status: ST_NOANC};
                    n_state = S_DONE;
                end else begin
                    n_guard = guard_inc;
                    n_state = S_MEET_PP;
                end
            end
            S_MEET_PP: begin
                par_ra = r_q[AW-1:0];
                if (par_bad) begin
                    n_res   = '{ancestor: '0, status: ST_NOANC};
                    n_state = S_DONE;
                end else begin
                    n_p     = r_par_rd[NODE_W-1:0];
                    n_state = S_MEET_PQ;
                end
            end
            S_MEET_PQ: begin
                if (par_bad) begin
                    n_res   = '{ancestor: '0, status: ST_NOANC};
                    n_state = S_DONE;
                end else begin
                    n_q     = r_par_rd[NODE_W-1:0];
                    n_state = S_MEET;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v     <= n_v;
        r_cur   <= n_cur;
        r_steps <= n_steps;
        r_p     <= n_p;
        r_q     <= n_q;
        r_dp    <= n_dp;
        r_dq    <= n_dq;
        r_cyc   <= n_cyc;
        r_guard <= n_guard;
        r_res   <= n_res;
    end

    assign o_ctl.idle      = (r_state == S_IDLE);
    assign o_ctl.res_valid = (r_state == S_DONE);
    assign o_result        = r_res;

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import lcac_pkg::*;

    localparam int MAX_NODES       = 1024;
    localparam int NODE_CAP        = (MAX_NODES < FIELD_NODES) ? MAX_NODES : FIELD_NODES;
    localparam int IDLE_PCT        = 22;
    localparam int CALM_FROM       = 1300;
    localparam int CALM_TO         = 1500;
    localparam int CFG_SETTLE      = 8;
    localparam int TAIL_CYCLES     = 64;
    localparam int WATCHDOG_LIMIT  = 200000;
    localparam int MAX_REPORTS     = 10;
    localparam int MIX_PER_PHASE   = 50;
    localparam int MIX_TARGET      = 950;

    typedef enum int {SHAPE_TREE, SHAPE_CHAIN, SHAPE_FOREST, SHAPE_WILD} tree_shape_e;

    typedef struct {
        bit               is_cfg;
        t_in_item         req;
        logic [CNT_W-1:0] cnt;
    } lca_cmd_t;

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             req_valid  = 1'b0;
    t_in_item         req_item   = '0;
    logic             res_ready  = 1'b0;
    logic             cfg_valid  = 1'b0;
    logic [CNT_W-1:0] cfg_data   = '0;
    logic             req_ready;
    logic             res_valid;
    t_out_item        res_item;
    logic             cfg_ready;

    lca_cmd_t         pending_cmds[$];
    t_out_item        anc_expect_q[$];

    // shadow of the block state
    logic [CNT_W-1:0]  node_cnt_shadow = 11'd1024;
    logic [CNT_W-1:0]  parent_mem [FIELD_NODES];
    logic [NODE_W-1:0] depth_mem  [FIELD_NODES];
    bit                loop_flag  [FIELD_NODES];

    bit req_taken    = 1'b0;
    bit cfg_taken    = 1'b0;
    int req_count    = 0;
    int settle_cnt   = 0;
    int stall_cycles = 0;
    int mismatch_cnt = 0;

    lowest_common_ancestor_climb_core #(
        .MAX_NODES(MAX_NODES)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (req_valid),
        .o_ready    (req_ready),
        .i_item     (req_item),
        .o_valid    (res_valid),
        .i_ready    (res_ready),
        .o_result   (res_item),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int active_limit();
        int n;
        n = node_cnt_shadow;
        if (n < 1) n = 1;
        if (n > NODE_CAP) n = NODE_CAP;
        return n;
    endfunction

    function automatic bit next_parent(int v, int lim, output int up);
        int p;
        p  = parent_mem[v];
        up = 0;
        if (p == NO_PARENT || p >= lim) return 1'b0;
        up = p;
        return 1'b1;
    endfunction

    function automatic void compute_depths(int lim);
        int cur, steps, up;
        bit reached;
        for (int v = 0; v < lim; v++) begin
            cur     = v;
            steps   = 0;
            reached = 1'b0;
            while (steps < lim && !reached) begin
                if (!next_parent(cur, lim, up)) begin
                    reached = 1'b1;
                end else begin
                    cur = up;
                    steps++;
                end
            end
            loop_flag[v] = !reached;
            depth_mem[v] = reached ? NODE_W'(steps) : '0;
        end
    endfunction

    function automatic t_out_item climb_lca(int p, int q, int lim);
        t_out_item r;
        int guard, up, up2;
        r.ancestor = '0;
        r.status   = ST_NOANC;
        if (p >= lim || q >= lim) begin
            r.status = ST_RANGE;
            return r;
        end
        if (loop_flag[p] || loop_flag[q]) return r;
        // lift the deeper node until the depths agree
        guard = 0;
        while (depth_mem[p] != depth_mem[q]) begin
            guard++;
            if (guard > 2 * lim) return r;
            if (depth_mem[p] > depth_mem[q]) begin
                if (!next_parent(p, lim, up)) return r;
                p = up;
            end else begin
                if (!next_parent(q, lim, up)) return r;
                q = up;
            end
        end
        guard = 0;
        while (p != q) begin
            guard++;
            if (guard > lim) return r;
            if (!next_parent(p, lim, up) || !next_parent(q, lim, up2)) return r;
            p = up;
            q = up2;
        end
        r.ancestor = NODE_W'(p);
        r.status   = ST_OK;
        return r;
    endfunction

    function automatic void apply_request(t_in_item it);
        int lim;
        lim = active_limit();
        case (it.action)
            ACT_LOAD: begin
                if (it.node_a < lim)
                    parent_mem[it.node_a] = it.has_parent ? {1'b0, it.node_b} : NO_PARENT;
            end
            ACT_PREP:  compute_depths(lim);
            ACT_QUERY: anc_expect_q.push_back(climb_lca(it.node_a, it.node_b, lim));
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic bit chance(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic void push_req(logic [1:0] act, int a, int b, logic hp);
        lca_cmd_t cmd;
        cmd.is_cfg         = 1'b0;
        cmd.cnt            = '0;
        cmd.req.action     = act;
        cmd.req.node_a     = NODE_W'(a);
        cmd.req.node_b     = NODE_W'(b);
        cmd.req.has_parent = hp;
        pending_cmds.push_back(cmd);
    endfunction

    function automatic void pick_parent(tree_shape_e shape, int node, int lim,
                                        output logic hp, output logic [NODE_W-1:0] par);
        int r;
        hp  = 1'b1;
        par = NODE_W'($urandom_range(0, FIELD_NODES - 1));
        case (shape)
            SHAPE_WILD: begin
                // loops, parents past the limit and roots all show up here
                hp = chance(85);
                r  = $urandom_range(0, 99);
                if (r < 70) par = NODE_W'($urandom_range(0, lim - 1));
                else if (r < 90) par = NODE_W'(lim + $urandom_range(0, 3));
            end
            SHAPE_CHAIN: begin
                if (node == 0) hp = 1'b0;
                else par = NODE_W'(node - 1);
            end
            SHAPE_FOREST: begin
                if (node < 3) hp = 1'b0;
                else par = NODE_W'($urandom_range(0, node - 1));
            end
            default: begin
                if (node == 0 || chance(10)) hp = 1'b0;
                else par = NODE_W'($urandom_range(0, node - 1));
            end
        endcase
    endfunction

    // Returns how many of the added requests do real work.
    function automatic int add_mixed_requests(int lim, tree_shape_e shape, int count);
        int roll, a, b, counted;
        logic hp;
        logic [NODE_W-1:0] par;
        bit big;
        counted = 0;
        big     = (lim == NODE_CAP);
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
                a = (big || chance(85)) ? $urandom_range(0, lim - 1)
                                        : $urandom_range(0, FIELD_NODES - 1);
                b = (big || chance(85)) ? $urandom_range(0, lim - 1)
                                        : $urandom_range(0, FIELD_NODES - 1);
                if (chance(10)) b = a;
                push_req(ACT_QUERY, a, b, chance(50));
                counted++;
            end else if (roll < 80) begin
                if (big) begin
                    // keep the large tree acyclic so prepare stays short
                    a   = $urandom_range(1, FIELD_NODES - 2);
                    hp  = chance(90);
                    par = hp ? NODE_W'($urandom_range(0, a - 1))
                             : NODE_W'($urandom_range(0, FIELD_NODES - 1));
                    counted++;
                end else begin
                    a = chance(85) ? $urandom_range(0, lim - 1)
                                   : $urandom_range(0, FIELD_NODES - 1);
                    pick_parent((lim <= 64 && chance(15)) ? SHAPE_WILD : shape, a, lim, hp, par);
                    if (a < lim) counted++;
                end
                push_req(ACT_LOAD, a, par, hp);
            end else if (roll < (big ? 84 : 90)) begin
                push_req(ACT_PREP, $urandom_range(0, FIELD_NODES - 1),
                         $urandom_range(0, FIELD_NODES - 1), chance(50));
                counted++;
            end else begin
                push_req(ACT_NONE, $urandom_range(0, FIELD_NODES - 1),
                         $urandom_range(0, FIELD_NODES - 1), chance(50));
            end
        end
        return counted;
    endfunction

    // ---------------------------------------------------------------- driver

    always @(negedge clk) begin : drive_proc
        logic             nxt_valid;
        t_in_item         nxt_item;
        logic             nxt_cfg_valid;
        logic [CNT_W-1:0] nxt_cfg_data;
        bit               calm;
        if (rst_n) begin
            calm          = (req_count >= CALM_FROM && req_count < CALM_TO);
            nxt_valid     = req_valid && !req_taken;
            nxt_item      = req_item;
            nxt_cfg_valid = cfg_valid && !cfg_taken;
            nxt_cfg_data  = cfg_data;
            req_taken     = 1'b0;
            cfg_taken     = 1'b0;
            if (!nxt_valid && !nxt_cfg_valid && pending_cmds.size() != 0) begin
                if (pending_cmds[0].is_cfg) begin
                    // hold the write until every query has answered and the block settled
                    if (anc_expect_q.size() != 0) begin
                        settle_cnt = 0;
                    end else if (settle_cnt < CFG_SETTLE) begin
                        settle_cnt++;
                    end else begin
                        nxt_cfg_valid = 1'b1;
                        nxt_cfg_data  = pending_cmds[0].cnt;
                        void'(pending_cmds.pop_front());
                        settle_cnt = 0;
                    end
                end else if (calm || $urandom_range(0, 99) >= IDLE_PCT) begin
                    nxt_valid = 1'b1;
                    nxt_item  = pending_cmds[0].req;
                    void'(pending_cmds.pop_front());
                end
            end
            req_valid <= nxt_valid;
            req_item  <= nxt_item;
            cfg_valid <= nxt_cfg_valid;
            cfg_data  <= nxt_cfg_data;
            res_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge clk) begin : check_proc
        t_out_item want;
        bit        progress;
        if (rst_n) begin
            progress = 1'b0;
            if (req_valid && req_ready) begin
                apply_request(req_item);
                req_taken = 1'b1;
                req_count++;
                progress = 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                node_cnt_shadow = cfg_data;
                cfg_taken       = 1'b1;
                progress        = 1'b1;
            end
            if (res_valid && res_ready) begin
                progress = 1'b1;
                if (anc_expect_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("unexpected ancestor result: ancestor %0d status %0d",
                                 res_item.ancestor, res_item.status);
                end else begin
                    want = anc_expect_q.pop_front();
                    if (want.ancestor !== res_item.ancestor || want.status !== res_item.status) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_REPORTS)
                            $display("ancestor mismatch: exp anc %0d st %0d, got anc %0d st %0d",
                                     want.ancestor, want.status,
                                     res_item.ancestor, res_item.status);
                    end
                end
            end
            if (progress) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin : stim_proc
        lca_cmd_t          cmd;
        logic [CNT_W-1:0]  cnt;
        logic              hp;
        logic [NODE_W-1:0] par;
        tree_shape_e       shape;
        int                lim, load_top, mix_total, phase, i;

        // full tree at the reset limit, every entry written once
        for (i = 0; i < NODE_CAP; i++) begin
            pick_parent(SHAPE_TREE, i, NODE_CAP, hp, par);
            push_req(ACT_LOAD, i, par, hp);
        end
        push_req(ACT_PREP, 0, 0, 1'b0);
        push_req(ACT_QUERY, 0, 0, 1'b0);
        push_req(ACT_QUERY, 0, FIELD_NODES - 1, 1'b1);
        push_req(ACT_QUERY, FIELD_NODES - 1, FIELD_NODES - 1, 1'b0);
        push_req(ACT_QUERY, FIELD_NODES - 2, FIELD_NODES - 3, 1'b0);
        push_req(ACT_NONE, FIELD_NODES - 1, FIELD_NODES - 1, 1'b1);
        // self loop on the top node, then queries that touch it
        push_req(ACT_LOAD, FIELD_NODES - 1, FIELD_NODES - 1, 1'b1);
        push_req(ACT_PREP, FIELD_NODES - 1, FIELD_NODES - 1, 1'b1);
        push_req(ACT_QUERY, FIELD_NODES - 1, 7, 1'b0);
        push_req(ACT_QUERY, 7, FIELD_NODES - 1, 1'b0);
        // cut a node loose and query on stale depths
        push_req(ACT_LOAD, 1000, 0, 1'b0);
        push_req(ACT_QUERY, 1000, 999, 1'b0);
        push_req(ACT_QUERY, 1000, 0, 1'b0);
        push_req(ACT_LOAD, 1000, 1, 1'b1);
        push_req(ACT_QUERY, 1000, 1, 1'b0);
        push_req(ACT_PREP, 0, 0, 1'b0);
        push_req(ACT_QUERY, 1000, 1, 1'b0);
        mix_total = add_mixed_requests(NODE_CAP, SHAPE_TREE, MIX_PER_PHASE);

        phase = 0;
        while (mix_total < MIX_TARGET) begin
            // fence query: its answer proves the last prepare is done
            push_req(ACT_QUERY, 0, 0, 1'b0);
            case (phase)
                0:       cnt = 11'd0;
                1:       cnt = 11'd1;
                2:       cnt = 11'd2;
                3:       cnt = 11'd2047;
                4:       cnt = 11'd3;
                default: cnt = chance(20) ? CNT_W'($urandom_range(100, 300))
                                          : CNT_W'($urandom_range(4, 40));
            endcase
            cmd.is_cfg = 1'b1;
            cmd.req    = '0;
            cmd.cnt    = cnt;
            pending_cmds.push_back(cmd);
            lim = (cnt == 0) ? 1 : (cnt > NODE_CAP) ? NODE_CAP : int'(cnt);
            if (lim == NODE_CAP) shape = SHAPE_TREE;
            else if (lim <= 3) shape = SHAPE_WILD;
            else if (lim > 64) shape = chance(50) ? SHAPE_TREE : SHAPE_FOREST;
            else shape = tree_shape_e'($urandom_range(0, 3));
            // at full size only the low nodes are reloaded; the rest stay from the first tree
            load_top = (lim == NODE_CAP) ? 64 : lim;
            for (i = 0; i < load_top; i++) begin
                pick_parent(shape, i, lim, hp, par);
                push_req(ACT_LOAD, i, par, hp);
            end
            if (lim < NODE_CAP)
                push_req(ACT_LOAD, $urandom_range(lim, FIELD_NODES - 1), 0, 1'b1);
            push_req(ACT_PREP, 0, 0, 1'b0);
            mix_total += add_mixed_requests(lim, shape, MIX_PER_PHASE);
            phase++;
        end
        push_req(ACT_QUERY, 0, 0, 1'b0);

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || req_valid || cfg_valid || anc_expect_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatch_cnt == 0 && anc_expect_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
